>>> rtl/cspl_pkg.sv
package cspl_pkg;

  // Row geometry
  localparam int INTERVALS   = 7;
  localparam int MAX_SAMPLES = 32;

  // Fixed-point constants
  localparam logic [16:0]        Q16_ONE      = 17'h10000;
  localparam logic signed [51:0] HALF_Q16     = 52'sd32768;
  localparam logic [43:0]        HALF_DIVISOR = 44'd196608;      // 6 * 2^16 / 2
  localparam logic signed [25:0] RECIP_THREE  = 26'sd22369622;   // ceil(2^26 / 3)
  localparam logic [27:0]        SAT_POS_Q    = 28'd50331648;    // 6 * 2^23
  localparam logic [27:0]        SAT_NEG_Q    = 28'd50331654;    // 6 * (2^23 + 1)
  localparam logic [23:0]        SAMPLE_MAX   = 24'h7FFFFF;
  localparam logic [23:0]        SAMPLE_MIN   = 24'h800000;

  // Configuration register indexes
  localparam logic CFG_SAMPLES = 1'b0;
  localparam logic CFG_STEP    = 1'b1;

  typedef struct packed {
    logic signed [15:0] knot_value;
    logic signed [23:0] knot_curvature;
    logic               row_start;
  } knot_t;

  typedef struct packed {
    logic signed [23:0] sample_value;
    logic [10:0]        sample_position;
    logic               run_last;
    logic               row_last;
  } sample_t;

  typedef struct packed {
    logic [5:0]  samples;
    logic [16:0] step;
  } cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_CAPTURE,
    OP_UV,
    OP_MUU,
    OP_MU3,
    OP_MVV,
    OP_MV3,
    OP_MZU,
    OP_MZV,
    OP_MAU,
    OP_MAV,
    OP_RND,
    OP_DIV,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  k;
    logic [10:0] position;
    logic        run_last;
    logic        row_last;
    logic        commit;
  } cmd_t;

endpackage

>>> rtl/cspl_datapath.sv
module cspl_datapath (
  input  logic             clk,
  input  cspl_pkg::cfg_t   cfg,
  input  cspl_pkg::knot_t  knot,
  input  cspl_pkg::cmd_t   cmd,
  output cspl_pkg::sample_t sample
);

  // Knot registers: z and a = 6y - z for both ends of the interval
  logic signed [23:0] prev_z, cur_z;
  logic signed [24:0] prev_a, cur_a;
  logic signed [24:0] y_ext, a_in;

  // Per-sample working registers
  logic [16:0]        u, v, t, u3, v3;
  logic signed [43:0] acc;
  logic               neg, sat;
  logic [24:0]        h;
  logic [23:0]        quo;

  // Position and shared multiplier
  logic [22:0]        pos_prod;
  logic [16:0]        u_sat;
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] prod, prod_rnd;
  logic [43:0]        mag, mag_rnd;
  logic [27:0]        q;
  logic [23:0]        value;

  assign y_ext = 25'(knot.knot_value);
  assign a_in  = (y_ext <<< 2) + (y_ext <<< 1) - 25'(knot.knot_curvature);

  // u = k * step, clamped to one
  assign pos_prod = 23'(cmd.k) * 23'(cfg.step);
  assign u_sat    = (pos_prod > 23'(cspl_pkg::Q16_ONE)) ? cspl_pkg::Q16_ONE : pos_prod[16:0];

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      cspl_pkg::OP_MUU: begin
        mul_a = 26'($signed({1'b0, u}));
        mul_b = 26'($signed({1'b0, u}));
      end
      cspl_pkg::OP_MU3: begin
        mul_a = 26'($signed({1'b0, t}));
        mul_b = 26'($signed({1'b0, u}));
      end
      cspl_pkg::OP_MVV: begin
        mul_a = 26'($signed({1'b0, v}));
        mul_b = 26'($signed({1'b0, v}));
      end
      cspl_pkg::OP_MV3: begin
        mul_a = 26'($signed({1'b0, t}));
        mul_b = 26'($signed({1'b0, v}));
      end
      cspl_pkg::OP_MZU: begin
        mul_a = 26'(cur_z);
        mul_b = 26'($signed({1'b0, u3}));
      end
      cspl_pkg::OP_MZV: begin
        mul_a = 26'(prev_z);
        mul_b = 26'($signed({1'b0, v3}));
      end
      cspl_pkg::OP_MAU: begin
        mul_a = 26'(cur_a);
        mul_b = 26'($signed({1'b0, u}));
      end
      cspl_pkg::OP_MAV: begin
        mul_a = 26'(prev_a);
        mul_b = 26'($signed({1'b0, v}));
      end
      cspl_pkg::OP_DIV: begin
        mul_a = 26'($signed({1'b0, h}));
        mul_b = cspl_pkg::RECIP_THREE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_rnd = prod + cspl_pkg::HALF_Q16;

  // Magnitude, rounded and scaled down by 2^16 (the /6 follows)
  assign mag     = acc[43] ? 44'(-acc) : 44'(acc);
  assign mag_rnd = mag + cspl_pkg::HALF_DIVISOR;
  assign q       = mag_rnd[43:16];

  // Final value with sign and saturation
  always_comb begin
    if (sat) begin
      value = neg ? cspl_pkg::SAMPLE_MIN : cspl_pkg::SAMPLE_MAX;
    end else begin
      value = neg ? (~quo + 24'd1) : quo;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      cspl_pkg::OP_START: begin
        prev_z <= knot.knot_curvature;
        prev_a <= a_in;
      end
      cspl_pkg::OP_CAPTURE: begin
        cur_z <= knot.knot_curvature;
        cur_a <= a_in;
      end
      cspl_pkg::OP_UV: begin
        u <= u_sat;
        v <= cspl_pkg::Q16_ONE - u_sat;
      end
      cspl_pkg::OP_MUU, cspl_pkg::OP_MVV: t <= prod_rnd[32:16];
      cspl_pkg::OP_MU3: u3 <= prod_rnd[32:16];
      cspl_pkg::OP_MV3: v3 <= prod_rnd[32:16];
      cspl_pkg::OP_MZU: acc <= prod[43:0];
      cspl_pkg::OP_MZV, cspl_pkg::OP_MAU, cspl_pkg::OP_MAV: acc <= acc + prod[43:0];
      cspl_pkg::OP_RND: begin
        neg <= acc[43];
        sat <= acc[43] ? (q >= cspl_pkg::SAT_NEG_Q) : (q >= cspl_pkg::SAT_POS_Q);
        h   <= q[25:1];
      end
      cspl_pkg::OP_DIV: quo <= prod[49:26];
      cspl_pkg::OP_EMIT: begin
        sample.sample_value    <= value;
        sample.sample_position <= cmd.position;
        sample.run_last        <= cmd.run_last;
        sample.row_last        <= cmd.row_last;
        if (cmd.commit) begin
          prev_z <= cur_z;
          prev_a <= cur_a;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/cspl_ctrl.sv
module cspl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  cspl_pkg::cfg_t cfg,
  input  logic           knot_valid,
  input  logic           knot_row_start,
  output logic           knot_stall,
  output logic           sample_valid,
  input  logic           sample_stall,
  output cspl_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_UV   = 13'b0000000000010,
    S_MUU  = 13'b0000000000100,
    S_MU3  = 13'b0000000001000,
    S_MVV  = 13'b0000000010000,
    S_MV3  = 13'b0000000100000,
    S_MZU  = 13'b0000001000000,
    S_MZV  = 13'b0000010000000,
    S_MAU  = 13'b0000100000000,
    S_MAV  = 13'b0001000000000,
    S_RND  = 13'b0010000000000,
    S_DIV  = 13'b0100000000000,
    S_EMIT = 13'b1000000000000
  } state_t;

  state_t      state, state_next;
  logic [5:0]  knot_count;
  logic [10:0] position;
  logic [5:0]  k;
  logic [5:0]  n;
  logic        last_interval;
  logic [5:0]  n_clamped;
  logic        opens_row;
  logic        final_sample;
  logic        slot_free;

  assign opens_row    = knot_row_start || (knot_count == 6'd0);
  assign final_sample = (k == n - 6'd1);
  assign slot_free    = !sample_valid || !sample_stall;

  always_comb begin
    if (cfg.samples < 6'd2) begin
      n_clamped = 6'd2;
    end else if (cfg.samples > 6'(cspl_pkg::MAX_SAMPLES)) begin
      n_clamped = 6'(cspl_pkg::MAX_SAMPLES);
    end else begin
      n_clamped = cfg.samples;
    end
  end

  // Sequencing and command decode
  always_comb begin
    state_next    = state;
    knot_stall    = 1'b1;
    cmd.op        = cspl_pkg::OP_NONE;
    cmd.k         = k;
    cmd.position  = position;
    cmd.run_last  = final_sample;
    cmd.row_last  = final_sample && last_interval;
    cmd.commit    = final_sample;
    unique case (state)
      S_IDLE: begin
        knot_stall = 1'b0;
        if (knot_valid) begin
          cmd.op     = opens_row ? cspl_pkg::OP_START : cspl_pkg::OP_CAPTURE;
          state_next = opens_row ? S_IDLE : S_UV;
        end
      end
      S_UV: begin
        cmd.op     = cspl_pkg::OP_UV;
        state_next = S_MUU;
      end
      S_MUU: begin
        cmd.op     = cspl_pkg::OP_MUU;
        state_next = S_MU3;
      end
      S_MU3: begin
        cmd.op     = cspl_pkg::OP_MU3;
        state_next = S_MVV;
      end
      S_MVV: begin
        cmd.op     = cspl_pkg::OP_MVV;
        state_next = S_MV3;
      end
      S_MV3: begin
        cmd.op     = cspl_pkg::OP_MV3;
        state_next = S_MZU;
      end
      S_MZU: begin
        cmd.op     = cspl_pkg::OP_MZU;
        state_next = S_MZV;
      end
      S_MZV: begin
        cmd.op     = cspl_pkg::OP_MZV;
        state_next = S_MAU;
      end
      S_MAU: begin
        cmd.op     = cspl_pkg::OP_MAU;
        state_next = S_MAV;
      end
      S_MAV: begin
        cmd.op     = cspl_pkg::OP_MAV;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.op     = cspl_pkg::OP_RND;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op     = cspl_pkg::OP_DIV;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // wait here until the output register is free
        if (slot_free) begin
          cmd.op     = cspl_pkg::OP_EMIT;
          state_next = final_sample ? S_IDLE : S_UV;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      knot_count    <= '0;
      position      <= '0;
      k             <= '0;
      n             <= 6'd2;
      last_interval <= 1'b0;
      sample_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // knot accepted: open a row or set up the interval
      if (state == S_IDLE && knot_valid) begin
        if (opens_row) begin
          knot_count <= 6'd1;
          position   <= '0;
        end else begin
          k             <= (knot_count == 6'd1) ? 6'd0 : 6'd1;
          n             <= n_clamped;
          last_interval <= (knot_count >= 6'(cspl_pkg::INTERVALS));
        end
      end

      // sample handed to the output register
      if (cmd.op == cspl_pkg::OP_EMIT) begin
        position <= position + 11'd1;
        if (final_sample) begin
          knot_count <= last_interval ? 6'd0 : knot_count + 6'd1;
        end else begin
          k <= k + 6'd1;
        end
      end

      if (cmd.op == cspl_pkg::OP_EMIT) begin
        sample_valid <= 1'b1;
      end else if (!sample_stall) begin
        sample_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && slot_free && final_sample) |=> (state == S_IDLE))
    else $error("final sample of a knot did not return to idle");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (k < n))
    else $error("sample index beyond interval");

  a_knot_count_bound: assert property (@(posedge clk) disable iff (rst)
    knot_count <= 6'(cspl_pkg::INTERVALS))
    else $error("knot count beyond row length");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> ($past(state) == S_EMIT))
    else $error("output word raised outside emit step");
`endif

endmodule

>>> rtl/cubic_spline_segment_evaluator_core.sv
// Channel  | Handshake                  | Word
// ---------+----------------------------+------------------------------------------
// knot     | knot_valid / knot_stall    | knot_value, knot_curvature, row_start
// sample   | sample_valid / sample_stall| sample_value, sample_position, run_last,
//          |                            | row_last
// cfg      | cfg_write (no handshake)   | cfg_index, cfg_data
//
// A row-start knot, or any knot while no row is open, is taken and emits nothing.
// Other knots are captured and then give up to 32 samples, each made of a position
// step, eight products and the divide-by-three reciprocal on the one shared 26x26
// multiplier, a rounding step, and one emit.
// The emit step waits while the output register holds an untaken word.
// The next knot is taken as soon as the last sample sits in the output register.
// Synchronous active-high reset; row state clears, configuration returns to
// 8 samples per interval and step 9362.
module cubic_spline_segment_evaluator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              knot_valid,
  output logic              knot_stall,
  input  cspl_pkg::knot_t   knot,
  output logic              sample_valid,
  input  logic              sample_stall,
  output cspl_pkg::sample_t sample,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [16:0]       cfg_data
);

  cspl_pkg::cfg_t cfg;
  cspl_pkg::cmd_t cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples <= 6'd8;
      cfg.step    <= 17'd9362;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cspl_pkg::CFG_SAMPLES: cfg.samples <= cfg_data[5:0];
        cspl_pkg::CFG_STEP:    cfg.step    <= cfg_data;
      endcase
    end
  end

  cspl_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .knot_valid     (knot_valid),
    .knot_row_start (knot.row_start),
    .knot_stall     (knot_stall),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .cmd            (cmd)
  );

  cspl_datapath u_datapath (
    .clk    (clk),
    .cfg    (cfg),
    .knot   (knot),
    .cmd    (cmd),
    .sample (sample)
  );

endmodule

>>> tb/sv/cubic_spline_segment_evaluator_core_tb.sv
module cubic_spline_segment_evaluator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the sample words of each accepted knot and checks them in order
  class spline_scoreboard;
    logic [5:0]             samples_reg;
    logic [16:0]            step_reg;
    logic signed [15:0]     last_value;
    logic signed [23:0]     last_curvature;
    logic [5:0]             knots_in_row;
    logic [10:0]            next_position;
    cspl_pkg::sample_t      pending_q[$];
    int                     errors;

    function new();
      samples_reg    = 6'd8;
      step_reg       = 17'd9362;
      last_value     = '0;
      last_curvature = '0;
      knots_in_row   = '0;
      next_position  = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic idx, logic [16:0] data);
      if (idx == cspl_pkg::CFG_SAMPLES) begin
        samples_reg = data[5:0];
      end else begin
        step_reg = data;
      end
    endfunction

    // Q16 cube, rounded after each product
    function longint cube_frac(longint a);
      longint sq;
      sq = (a * a + 32768) >>> 16;
      return (sq * a + 32768) >>> 16;
    endfunction

    function logic [23:0] spline_point(longint y0, longint z0, longint y1, longint z1,
                                       longint u);
      longint v, num, q;
      v   = 65536 - u;
      num = z1 * cube_frac(u) + z0 * cube_frac(v) + (6 * y1 - z1) * u + (6 * y0 - z0) * v;
      // divide by 6 * 2^16, ties away from zero
      if (num >= 0) begin
        q = (num + 196608) / 393216;
      end else begin
        q = -((-num + 196608) / 393216);
      end
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      return q[23:0];
    endfunction

    function void note_knot(cspl_pkg::knot_t w);
      longint            y1, z1, u;
      int                n, first_k;
      logic              last_interval;
      cspl_pkg::sample_t s;
      y1 = w.knot_value;
      z1 = w.knot_curvature;
      // row start, or no row open: store the knot, nothing comes out
      if (w.row_start || knots_in_row == 0) begin
        last_value     = w.knot_value;
        last_curvature = w.knot_curvature;
        knots_in_row   = 6'd1;
        next_position  = '0;
        return;
      end
      n = samples_reg;
      if (n < 2) n = 2;
      if (n > cspl_pkg::MAX_SAMPLES) n = cspl_pkg::MAX_SAMPLES;
      last_interval = (knots_in_row >= cspl_pkg::INTERVALS);
      // later intervals skip the shared start point
      first_k = (knots_in_row == 6'd1) ? 0 : 1;
      for (int j = first_k; j < n; j++) begin
        u = longint'(j) * longint'(step_reg);
        if (u > 65536) u = 65536;
        s.sample_value    = spline_point(last_value, last_curvature, y1, z1, u);
        s.sample_position = next_position;
        s.run_last        = (j == n - 1);
        s.row_last        = (j == n - 1) && last_interval;
        pending_q.push_back(s);
        next_position = next_position + 11'd1;
      end
      last_value     = w.knot_value;
      last_curvature = w.knot_curvature;
      knots_in_row   = last_interval ? 6'd0 : knots_in_row + 6'd1;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_sample(cspl_pkg::sample_t got);
      cspl_pkg::sample_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("sample word with none predicted (value %0d position %0d)",
                                  got.sample_value, got.sample_position));
        return;
      end
      want = pending_q.pop_front();
      if (got.sample_value !== want.sample_value)
        report_mismatch($sformatf("position %0d: sample_value %0d, predicted %0d",
                                  want.sample_position, got.sample_value,
                                  want.sample_value));
      if (got.sample_position !== want.sample_position)
        report_mismatch($sformatf("sample_position %0d, predicted %0d",
                                  got.sample_position, want.sample_position));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("position %0d: run_last %b, predicted %b",
                                  want.sample_position, got.run_last, want.run_last));
      if (got.row_last !== want.row_last)
        report_mismatch($sformatf("position %0d: row_last %b, predicted %b",
                                  want.sample_position, got.row_last, want.row_last));
    endtask
  endclass

  localparam int LONG_HOLD = 800;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              knot_valid   = 1'b0;
  logic              knot_stall;
  cspl_pkg::knot_t   knot_word    = '0;
  logic              sample_valid;
  logic              sample_stall = 1'b0;
  cspl_pkg::sample_t sample_word;
  logic              cfg_write    = 1'b0;
  logic              cfg_index    = cspl_pkg::CFG_SAMPLES;
  logic [16:0]       cfg_data     = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int knots_sent    = 0;

  spline_scoreboard sb = new();

  cubic_spline_segment_evaluator_core u_top (
    .clk,
    .rst,
    .knot_valid,
    .knot_stall,
    .knot(knot_word),
    .sample_valid,
    .sample_stall,
    .sample(sample_word),
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (rst) begin
      sample_stall <= 1'b0;
    end else if (hold_left > 0) begin
      sample_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen    <= hold_asked;
      hold_left    <= LONG_HOLD;
      sample_stall <= 1'b1;
    end else begin
      sample_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Sample monitor
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) sb.check_sample(sample_word);
  end

  // Offer one knot word, with random idle cycles first, until taken
  task automatic send_knot(input logic signed [15:0] y, input logic signed [23:0] z,
                           input logic start);
    cspl_pkg::knot_t w;
    w.knot_value     = y;
    w.knot_curvature = z;
    w.row_start      = start;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      knot_valid <= 1'b0;
      @(negedge clk);
    end
    knot_word  <= w;
    knot_valid <= 1'b1;
    do @(posedge clk); while (knot_stall);
    sb.note_knot(w);
    knots_sent++;
  endtask

  // Stop offering and wait until every predicted sample has come out
  task automatic wait_quiet();
    @(negedge clk);
    knot_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [16:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input int n, input logic [16:0] step);
    write_reg(cspl_pkg::CFG_SAMPLES, 17'(n));
    write_reg(cspl_pkg::CFG_STEP, step);
  endtask

  function automatic logic [16:0] step_for(input int n);
    return 17'((65536 + (n - 1) / 2) / (n - 1));
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sd0;
      3:       return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [23:0] pick_curvature();
    case ($urandom_range(7))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return 24'sd0;
      3:       return 24'($urandom_range(65535)) - 24'd32768;
      default: return 24'($urandom);
    endcase
  endfunction

  // One row-shaped burst: mostly whole rows, some cut short, some noise
  task automatic send_row();
    int mode;
    mode = $urandom_range(9);
    if (mode <= 5) begin
      send_knot(pick_value(), pick_curvature(), 1'b1);
      repeat (cspl_pkg::INTERVALS) send_knot(pick_value(), pick_curvature(), 1'b0);
    end else if (mode == 6) begin
      // first knot without row_start: opens a row only if none is open
      send_knot(pick_value(), pick_curvature(), 1'b0);
      repeat (cspl_pkg::INTERVALS) send_knot(pick_value(), pick_curvature(), 1'b0);
    end else if (mode == 7) begin
      send_knot(pick_value(), pick_curvature(), 1'b1);
      repeat ($urandom_range(1, 5)) send_knot(pick_value(), pick_curvature(), 1'b0);
    end else begin
      repeat ($urandom_range(1, 3))
        send_knot(pick_value(), pick_curvature(), 1'($urandom_range(1)));
    end
  endtask

  task automatic send_random(input int count);
    int stop_at;
    stop_at = knots_sent + count;
    while (knots_sent < stop_at) send_row();
  endtask

  initial begin
    int n;
    send_idle_pct = 36;
    recv_idle_pct = 64;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset configuration, knot with no row open, field extremes,
    // row start in mid-row, a whole row, then a knot after the row is complete
    send_knot(16'sd0, 24'sd0, 1'b0);
    send_knot(16'sh7FFF, 24'sh7FFFFF, 1'b0);
    send_knot(16'sh8000, 24'sh800000, 1'b0);
    send_knot(-16'sd1, -24'sd1, 1'b0);
    send_knot(16'sd12345, 24'sh5A5A5A, 1'b1);
    send_knot(16'sd256, -24'sd4096, 1'b0);
    send_knot(-16'sd256, 24'sd4096, 1'b0);
    send_knot(16'sh7FFF, 24'sh800000, 1'b0);
    send_knot(16'sh8000, 24'sh7FFFFF, 1'b0);
    send_knot(16'sd0, 24'sd0, 1'b0);
    send_knot(16'sd1, 24'sd1, 1'b0);
    send_knot(-16'sd77, 24'sd99, 1'b0);
    send_knot(16'sd100, 24'sd200, 1'b0);
    wait_quiet();

    // Fewest samples, whole-interval step
    set_config(2, 17'd65536);
    send_knot(16'sd1000, -24'sd500, 1'b1);
    send_knot(-16'sd2000, 24'sd3000, 1'b0);
    send_knot(16'sd5, 24'sd5, 1'b0);
    wait_quiet();

    // Count above range is clamped; position saturates past the interval end
    set_config(63, 17'h1FFFF);
    send_knot(-16'sd7000, 24'sd1234567, 1'b1);
    send_knot(16'sd7000, -24'sd1234567, 1'b0);
    send_knot(16'sd0, 24'sd0, 1'b0);
    wait_quiet();

    // Count below range is clamped; zero step keeps every sample at u = 0
    set_config(0, 17'd0);
    send_knot(16'sd321, -24'sd321, 1'b1);
    send_knot(-16'sd321, 24'sd321, 1'b0);
    send_knot(16'sd42, 24'sd42, 1'b0);
    wait_quiet();

    // Most samples, finest step
    set_config(32, 17'd2114);
    send_knot(16'sd20000, 24'sd600000, 1'b1);
    send_knot(-16'sd20000, -24'sd600000, 1'b0);
    send_knot(16'sd1, -24'sd1, 1'b0);
    wait_quiet();

    // Random, sender idles less than the receiver; long hold-off in the middle
    set_config(5, step_for(5));
    send_idle_pct = 36;
    recv_idle_pct = 64;
    send_random(20);
    hold_asked++;
    send_random(45);
    wait_quiet();

    // Random, the other way round; sender pauses until all samples are out
    n = $urandom_range(2, 12);
    set_config(n, step_for(n));
    send_idle_pct = 64;
    recv_idle_pct = 36;
    send_random(30);
    wait_quiet();
    send_random(30);
    wait_quiet();

    // Random, no idling; odd steps, then a few rows at the largest size
    set_config(3, 17'($urandom_range(131071)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(40);
    wait_quiet();
    set_config(32, 17'd2114);
    send_random(15);

    wait_quiet();
    repeat (400) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report_mismatch($sformatf("%0d predicted sample words never came out",
                                   sb.pending_q.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
